// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH_DEFAULT    = 16;
  localparam int TAG_BITS_DEFAULT = 16;
  localparam int PRIO_BITS        = 32;
  localparam int IO_TAG_BITS      = 16;

  // operation field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DROPPED  = 2'd3
  } spq_status_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: compare, hold, or take from a neighbor.
`timescale 1ns / 1ps

module spq_cell #(
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEFAULT
) (
  input  logic                          clk,
  input  spq_pkg::spq_cmd_t             cmd,
  input  logic                          occupied,
  input  logic [spq_pkg::PRIO_BITS-1:0] in_priority,
  input  logic [TAG_BITS-1:0]           in_tag,
  input  logic                          prev_greater,
  input  logic [spq_pkg::PRIO_BITS-1:0] prev_priority,
  input  logic [TAG_BITS-1:0]           prev_tag,
  input  logic [spq_pkg::PRIO_BITS-1:0] next_priority,
  input  logic [TAG_BITS-1:0]           next_tag,
  output logic [spq_pkg::PRIO_BITS-1:0] priority_q,
  output logic [TAG_BITS-1:0]           tag_q,
  output logic                          greater
);
  import spq_pkg::*;

  // Entry stays ahead of the new item only if strictly higher.
  assign greater = occupied && (priority_q > in_priority);

  always_ff @(posedge clk) begin
    if (cmd.ins && !greater) begin
      if (prev_greater) begin
        priority_q <= in_priority;
        tag_q      <= in_tag;
      end else begin
        priority_q <= prev_priority;
        tag_q      <= prev_tag;
      end
    end else if (cmd.pop) begin
      priority_q <= next_priority;
      tag_q      <= next_tag;
    end
  end

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: cell chain, fill count, result register.
`timescale 1ns / 1ps
//
//  channel  dir  handshake              beat contents
//  -------  ---  ---------------------  -------------------------------------
//  input    in   in_valid / in_ready    operation, item_priority, item_tag
//  result   out  out_valid / out_ready  status, out_priority, out_tag
//
//  One beat in gives one beat out, in the next cycle; a new input beat is taken
//  every cycle while the result register is empty or being drained.
//  The rate is set by the cell chain: every cell compares against the new
//  priority at once and shifts one slot in the same cycle, so neither insert
//  nor pop depends on how full the queue is.
//  Reset (rst, synchronous) empties the queue and the result register at once;
//  stored entries are not cleared, the fill count alone marks them live.
//  A stalled result (out_ready low) holds in_ready low until it is taken.
//
//  Slot 0 holds the highest priority; slots descend from there. An insert
//  lands in front of every entry of equal or lower priority, so among equal
//  priorities the newest is nearest slot 0 and leaves first.

module sorted_priority_queue_core #(
  parameter int DEPTH    = spq_pkg::DEPTH_DEFAULT,
  parameter int TAG_BITS = spq_pkg::TAG_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic [spq_pkg::PRIO_BITS-1:0]    item_priority,
  input  logic [spq_pkg::IO_TAG_BITS-1:0]  item_tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [spq_pkg::PRIO_BITS-1:0]    out_priority,
  output logic [spq_pkg::IO_TAG_BITS-1:0]  out_tag
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [TAG_BITS-1:0]  tag_in;
  spq_cmd_t             cmd;

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;

  logic [PRIO_BITS-1:0] cell_priority [DEPTH];
  logic [TAG_BITS-1:0]  cell_tag      [DEPTH];
  logic                 cell_greater  [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  // Tag stored at TAG_BITS: truncate or zero-extend the 16-bit field.
  assign tag_in   = TAG_BITS'(item_tag);

  assign cmd.ins = accept && (operation == OP_INSERT) && !full;
  assign cmd.pop = accept && (operation == OP_POP) && !empty;

  // Cell chain: neighbors on both sides; the ends see constants.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 prev_greater;
    logic [PRIO_BITS-1:0] prev_priority;
    logic [TAG_BITS-1:0]  prev_tag;
    logic [PRIO_BITS-1:0] next_priority;
    logic [TAG_BITS-1:0]  next_tag;

    if (i == 0) begin : g_head
      assign prev_greater  = 1'b1;
      assign prev_priority = '0;
      assign prev_tag      = '0;
    end else begin : g_body
      assign prev_greater  = cell_greater[i-1];
      assign prev_priority = cell_priority[i-1];
      assign prev_tag      = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_priority = '0;
      assign next_tag      = '0;
    end else begin : g_link
      assign next_priority = cell_priority[i+1];
      assign next_tag      = cell_tag[i+1];
    end

    spq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .occupied     (count > CW'(i)),
      .in_priority  (item_priority),
      .in_tag       (tag_in),
      .prev_greater (prev_greater),
      .prev_priority(prev_priority),
      .prev_tag     (prev_tag),
      .next_priority(next_priority),
      .next_tag     (next_tag),
      .priority_q   (cell_priority[i]),
      .tag_q        (cell_tag[i]),
      .greater      (cell_greater[i])
    );
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: slot 0 is the head of the queue.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (operation == OP_INSERT) begin
        status       <= full ? ST_DROPPED : ST_INSERTED;
        out_priority <= '0;
        out_tag      <= '0;
      end else if (empty) begin
        status       <= ST_EMPTY;
        out_priority <= '0;
        out_tag      <= '0;
      end else begin
        status       <= ST_POPPED;
        out_priority <= cell_priority[0];
        out_tag      <= IO_TAG_BITS'(cell_tag[0]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_INSERT && !full) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the queue");

  a_empty_pop : assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_POP && empty) |=> (status == ST_EMPTY && count == '0))
    else $error("pop on empty queue misreported");

  for (genvar i = 0; i + 1 < DEPTH; i++) begin : g_sorted_chk
    a_sorted : assert property (@(posedge clk) disable iff (rst)
      (count > CW'(i + 1)) |-> (cell_priority[i] >= cell_priority[i+1]))
      else $error("cell chain out of order");
  end

endmodule
